### design/rycc_pkg.sv
// Shared types, fixed-point coefficients and helper functions for the BT.601 color converter.
// Used by every stage module and by the top level; depends on nothing else.
package rycc_pkg;

  // Fraction bits of every fixed-point coefficient and intermediate sum.
  localparam int FRAC_BITS = 16;

  // Coefficients are below 2.0, so one integer bit plus sign suffices.
  localparam int COEF_W = FRAC_BITS + 2;
  // Signed 9-bit operand (sample, or sample minus 128, or sample minus luma).
  localparam int OPND_W = 9;
  localparam int PROD_W = COEF_W + OPND_W;
  localparam int SUM_W  = PROD_W + 2;

  typedef logic        [7:0]        sample_t;
  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [OPND_W-1:0] opnd_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  // round(c * 2^FRAC_BITS), halves up
  localparam coef_t K_Y_R   = coef_t'(((longint'(299)  << FRAC_BITS) + 500)  / 1000);
  localparam coef_t K_Y_G   = coef_t'(((longint'(587)  << FRAC_BITS) + 500)  / 1000);
  localparam coef_t K_Y_B   = coef_t'(((longint'(114)  << FRAC_BITS) + 500)  / 1000);
  localparam coef_t K_CB    = coef_t'(((longint'(5643) << FRAC_BITS) + 5000) / 10000);
  localparam coef_t K_CR    = coef_t'(((longint'(7132) << FRAC_BITS) + 5000) / 10000);
  localparam coef_t K_B_CB  = coef_t'(((longint'(1772) << FRAC_BITS) + 500)  / 1000);
  localparam coef_t K_G_CR  = coef_t'(((longint'(714)  << FRAC_BITS) + 500)  / 1000);
  localparam coef_t K_G_CB  = coef_t'(((longint'(344)  << FRAC_BITS) + 500)  / 1000);
  localparam coef_t K_R_CR  = coef_t'(((longint'(1402) << FRAC_BITS) + 500)  / 1000);

  localparam opnd_t CHROMA_MID = opnd_t'(128);
  localparam sum_t  CHROMA_OFS = sum_t'(longint'(128) << FRAC_BITS);

  localparam logic DIR_FWD = 1'b0;
  localparam logic DIR_INV = 1'b1;

  typedef struct packed {
    sample_t sample_a;
    sample_t sample_b;
    sample_t sample_c;
  } pixel_t;

  typedef struct packed {
    sample_t result_a;
    sample_t result_b;
    sample_t result_c;
  } result_t;

  // Stage 1 -> stage 2: products of the first multiply bank
  typedef struct packed {
    logic    dir;
    sample_t a;
    sample_t c;
    prod_t   m0;
    prod_t   m1;
    prod_t   m2;
    prod_t   m3;
  } s1_t;

  // Stage 2 -> stage 3: luma (forward) or finished pixel (inverse)
  typedef struct packed {
    logic    dir;
    sample_t a;
    sample_t c;
    result_t res;
  } s2_t;

  // Stage 3 -> stage 4: chroma products (forward)
  typedef struct packed {
    logic    dir;
    prod_t   p_cb;
    prod_t   p_cr;
    result_t res;
  } s3_t;

  function automatic opnd_t zext(input sample_t s);
    return opnd_t'({1'b0, s});
  endfunction

  function automatic prod_t mul(input coef_t k, input opnd_t x);
    return prod_t'(prod_t'(k) * prod_t'(x));
  endfunction

  function automatic sum_t luma_term(input sample_t s);
    return sum_t'({1'b0, s}) << FRAC_BITS;
  endfunction

  // floor(v / 2^FRAC_BITS) clamped to 0..255
  function automatic sample_t floor_clamp(input sum_t v);
    sample_t r;
    if (v[SUM_W-1]) begin
      r = '0;
    end else if (|v[SUM_W-2:FRAC_BITS+8]) begin
      r = 8'hFF;
    end else begin
      r = v[FRAC_BITS+7:FRAC_BITS];
    end
    return r;
  endfunction

endpackage

### design/rycc_mult_stage.sv
// First pipeline stage: operand select and the shared multiply bank.
// Depends on rycc_pkg.
module rycc_mult_stage (
  input  logic            clk,
  input  logic            rst,
  input  logic            dir,
  input  logic            in_valid,
  input  rycc_pkg::pixel_t in_pix,
  output logic            out_valid,
  output rycc_pkg::s1_t   out_s1
);
  import rycc_pkg::*;

  opnd_t op_a;
  opnd_t op_b;
  opnd_t op_c;
  opnd_t cb;
  opnd_t cr;
  s1_t   s1_next;

  assign op_a = zext(in_pix.sample_a);
  assign op_b = zext(in_pix.sample_b);
  assign op_c = zext(in_pix.sample_c);
  assign cb   = op_b - CHROMA_MID;
  assign cr   = op_c - CHROMA_MID;

  always_comb begin
    s1_next.dir = dir;
    s1_next.a   = in_pix.sample_a;
    s1_next.c   = in_pix.sample_c;
    if (dir == DIR_FWD) begin
      s1_next.m0 = mul(K_Y_R, op_c);
      s1_next.m1 = mul(K_Y_G, op_b);
      s1_next.m2 = mul(K_Y_B, op_a);
      s1_next.m3 = '0;
    end else begin
      s1_next.m0 = mul(K_B_CB, cb);
      s1_next.m1 = mul(K_G_CR, cr);
      s1_next.m2 = mul(K_G_CB, cb);
      s1_next.m3 = mul(K_R_CR, cr);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_s1 <= s1_next;
  end

endmodule

### design/rycc_sum_stage.sv
// Second pipeline stage: sum products, floor and clamp luma or the inverse pixel.
// Depends on rycc_pkg.
module rycc_sum_stage (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  rycc_pkg::s1_t in_s1,
  output logic          out_valid,
  output rycc_pkg::s2_t out_s2
);
  import rycc_pkg::*;

  sum_t y_lin;
  s2_t  s2_next;

  assign y_lin = luma_term(in_s1.a);

  always_comb begin
    s2_next.dir = in_s1.dir;
    s2_next.a   = in_s1.a;
    s2_next.c   = in_s1.c;
    if (in_s1.dir == DIR_FWD) begin
      s2_next.res.result_a = floor_clamp(sum_t'(in_s1.m0) + sum_t'(in_s1.m1)
                                         + sum_t'(in_s1.m2));
      s2_next.res.result_b = '0;
      s2_next.res.result_c = '0;
    end else begin
      s2_next.res.result_a = floor_clamp(y_lin + sum_t'(in_s1.m0));
      s2_next.res.result_b = floor_clamp(y_lin - sum_t'(in_s1.m1) - sum_t'(in_s1.m2));
      s2_next.res.result_c = floor_clamp(y_lin + sum_t'(in_s1.m3));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_s2 <= s2_next;
  end

endmodule

### design/rycc_chroma_mult.sv
// Third pipeline stage: scale blue and red differences from luma for Cb and Cr.
// Depends on rycc_pkg.
module rycc_chroma_mult (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  rycc_pkg::s2_t in_s2,
  output logic          out_valid,
  output rycc_pkg::s3_t out_s3
);
  import rycc_pkg::*;

  opnd_t d_b;
  opnd_t d_r;
  s3_t   s3_next;

  assign d_b = zext(in_s2.a) - zext(in_s2.res.result_a);
  assign d_r = zext(in_s2.c) - zext(in_s2.res.result_a);

  always_comb begin
    s3_next.dir  = in_s2.dir;
    s3_next.res  = in_s2.res;
    s3_next.p_cb = mul(K_CB, d_b);
    s3_next.p_cr = mul(K_CR, d_r);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_s3 <= s3_next;
  end

endmodule

### design/rycc_out_stage.sv
// Fourth pipeline stage: offset and clamp chroma, select the result beat, drive the strobe.
// Depends on rycc_pkg.
module rycc_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  rycc_pkg::s3_t     in_s3,
  output logic              out_valid,
  output rycc_pkg::result_t out_res
);
  import rycc_pkg::*;

  result_t res_next;

  always_comb begin
    res_next = in_s3.res;
    if (in_s3.dir == DIR_FWD) begin
      res_next.result_b = floor_clamp(sum_t'(in_s3.p_cb) + CHROMA_OFS);
      res_next.result_c = floor_clamp(sum_t'(in_s3.p_cr) + CHROMA_OFS);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_res <= res_next;
  end

endmodule

### design/rgb_ycbcr_color_converter_top.sv
// BT.601 color converter top level: direction register, four-stage pipeline, assertions.
// Depends on rycc_pkg, rycc_mult_stage, rycc_sum_stage, rycc_chroma_mult, rycc_out_stage.
//
// Converts one pixel of three 8-bit samples per beat, BGR to YCbCr when direction is 0 and
// YCbCr back to BGR when direction is 1. A pixel is taken on every clock edge where start is
// high and busy is low; busy is high only during reset, so the block sustains one pixel per
// clock. Each result appears on the result port once its pixel has passed every stage, with
// done high for a single cycle; the receiver cannot stall, so it must capture the beat
// while done is high. The pipeline stages, in order, are a multiply bank, a sum and clamp
// of luma (or of the whole inverse pixel), a multiply of the blue and red differences from
// luma, and a final offset and clamp for Cb and Cr. Coefficients are fixed point with
// FRAC_BITS fraction bits; every output is floored and clamped to 0..255. The direction
// register takes a write only while the pipeline is empty and no pixel is being offered
// (cfg_ready high); bit 0 of cfg_data is stored. Results already in flight keep the
// direction they entered with.
module rgb_ycbcr_color_converter_top (
  input  logic              clk,
  input  logic              rst,
  // pixel input
  input  logic              start,
  output logic              busy,
  input  rycc_pkg::pixel_t  pixel,
  // result output
  output logic              done,
  output rycc_pkg::result_t result,
  // direction register write
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_data
);
  import rycc_pkg::*;

  logic    direction;
  logic    accept;
  logic    v1;
  logic    v2;
  logic    v3;
  s1_t     s1;
  s2_t     s2;
  s3_t     s3;

  // Busy only while reset holds the pipeline cleared.
  assign busy   = rst;
  assign accept = start && !busy;

  // Accept a direction write only with nothing in flight and nothing offered.
  assign cfg_ready = !rst && !start && !v1 && !v2 && !v3 && !done;

  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= DIR_FWD;
    end else if (cfg_valid && cfg_ready) begin
      direction <= cfg_data;
    end
  end

  // Stage 1: multiply bank, operands chosen by direction
  rycc_mult_stage u_mult (
    .clk       (clk),
    .rst       (rst),
    .dir       (direction),
    .in_valid  (accept),
    .in_pix    (pixel),
    .out_valid (v1),
    .out_s1    (s1)
  );

  // Stage 2: luma, or the full inverse pixel
  rycc_sum_stage u_sum (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v1),
    .in_s1     (s1),
    .out_valid (v2),
    .out_s2    (s2)
  );

  // Stage 3: chroma difference products
  rycc_chroma_mult u_chroma (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v2),
    .in_s2     (s2),
    .out_valid (v3),
    .out_s3    (s3)
  );

  // Stage 4: chroma offset and clamp, result register
  rycc_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v3),
    .in_s3     (s3),
    .out_valid (done),
    .out_res   (result)
  );

  // Every accepted pixel leaves the pipeline as a result beat.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##4 done)
    else $error("accepted pixel did not produce a result beat after four cycles");

  // No result beat without a matching accepted pixel.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, 4))
    else $error("result beat without a matching accepted pixel");

  // A direction write never lands while a pixel is in flight.
  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready) |-> (!v1 && !v2 && !v3 && !done && !accept))
    else $error("direction written while the pipeline holds a pixel");

  // Direction changes only through a completed write.
  a_dir_hold: assert property (@(posedge clk) disable iff (rst)
    !$past(cfg_valid && cfg_ready) && !$past(rst) |-> $stable(direction))
    else $error("direction changed without a write");

endmodule
